@@ rtl/binary_morphology_window_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Binary morphology window unit - assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BINARY_MORPHOLOGY_WINDOW_UNIT_DEFINES_SVH
`define BINARY_MORPHOLOGY_WINDOW_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BMW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define BMW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BMW_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define BMW_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/bmw_pkg.sv @@
// ----------------------------------------------------------------------------
// Binary morphology window package
// Sizes, register codes, shared types and the mask remapping function.
// ----------------------------------------------------------------------------
package bmw_pkg;

   localparam int MAX_LINE   = 1024;
   localparam int MAX_RADIUS = 3;

   localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
   localparam int STORE_BITS = 2 * MAX_RADIUS;
   localparam int WIN_BITS   = WIN_SIDE * WIN_SIDE;

   // structuring element register layout is fixed at 7x7, center 3
   localparam int SE_SPAN    = 7;
   localparam int SE_CENTER  = 3;
   localparam int SE_BITS    = SE_SPAN * SE_SPAN;

   localparam int LINE_AW    = $clog2(MAX_LINE);
   localparam int COL_W      = LINE_AW + 1;
   localparam int IW_W       = 11;
   localparam int CMP_W      = (COL_W > IW_W) ? COL_W : IW_W;
   localparam int ROW_W      = 16;
   localparam int RAD_W      = 2;
   localparam int CSR_IW     = 3;
   localparam int CSR_DW     = SE_BITS;

   typedef enum logic [CSR_IW-1:0] {
      CSR_MODE         = 3'd0,
      CSR_SE_MASK      = 3'd1,
      CSR_RADIUS_X     = 3'd2,
      CSR_RADIUS_Y     = 3'd3,
      CSR_IMAGE_WIDTH  = 3'd4,
      CSR_IMAGE_HEIGHT = 3'd5
   } csr_index_type;

   typedef enum logic {
      MODE_ERODE  = 1'b0,
      MODE_DILATE = 1'b1
   } mode_type;

   typedef struct packed {
      logic pixel_out;
      logic out_valid;
      logic frame_done;
   } rsp_type;

   typedef struct packed {
      logic any_set;
      logic all_set;
   } cell_flags_type;

   function automatic logic [RAD_W-1:0] clamp_radius(input logic [RAD_W-1:0] r);
      clamp_radius = (int'(r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r;
   endfunction

   // Remap the 7x7 structuring element into window layout
   // (column age a, row age b at bit a*WIN_SIDE+b), dropping offsets beyond the radii.
   function automatic logic [WIN_BITS-1:0] window_mask(input logic [SE_BITS-1:0] se,
                                                       input logic [RAD_W-1:0]   rx,
                                                       input logic [RAD_W-1:0]   ry);
      logic [WIN_BITS-1:0] m;
      int                  sel;
      m = '0;
      for (int a = 0; a < WIN_SIDE; a++) begin
         for (int b = 0; b < WIN_SIDE; b++) begin
            if (a <= 2 * int'(rx) && b <= 2 * int'(ry)) begin
               sel = (int'(ry) - b + SE_CENTER) * SE_SPAN + (int'(rx) - a + SE_CENTER);
               m[a*WIN_SIDE+b] = se[sel];
            end
         end
      end
      window_mask = m;
   endfunction

endpackage

@@ rtl/bmw_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bmw_cell.sv @@
// ----------------------------------------------------------------------------
// Window column cell
// Holds one window column, passes it to the next cell on every shift and
// flags any/all over the masked bits of the column it takes in.
// ----------------------------------------------------------------------------
module bmw_cell import bmw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  logic [WIN_SIDE-1:0] prev_col,
   input  logic [WIN_SIDE-1:0] mask,
   output logic [WIN_SIDE-1:0] col_out,
   output cell_flags_type      flags
);

   logic [WIN_SIDE-1:0] col_ff;
   logic [WIN_SIDE-1:0] col_in;

   assign col_in = shift_en ? prev_col : col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   // flags describe the column this cell holds after the shift
   assign flags.any_set = |(prev_col & mask);
   assign flags.all_set = &(prev_col | ~mask);
   assign col_out       = col_ff;

endmodule

@@ rtl/bmw_out_buf.sv @@
// ----------------------------------------------------------------------------
// Result output buffer
// Output register plus skid entry, so input ready does not depend combinationally on rsp_ready.
// ----------------------------------------------------------------------------
module bmw_out_buf import bmw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_load,
   input  rsp_type in_data,
   input  logic    out_ready,
   output logic    out_valid,
   output rsp_type out_data,
   output logic    full
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_data_ff,  main_data_in;
   rsp_type skid_data_ff,  skid_data_in;
   logic    take;

   assign take = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            // promote the skid entry
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (in_load) begin
            main_data_in  = in_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (in_load) begin
         if (!main_valid_ff) begin
            main_data_in  = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign full      = skid_valid_ff;

endmodule

@@ rtl/binary_morphology_window_unit.sv @@
// ----------------------------------------------------------------------------
// Binary morphology window unit
// Streaming binary erosion / dilation over a window of up to 7x7 pixels.
// ----------------------------------------------------------------------------
// Takes one binary pixel per transfer in raster order and returns exactly one
// result per pixel: the eroded or dilated value of the pixel radius_y rows up
// and radius_x columns left, with out_valid low while the window is still
// filling and frame_done high on the last pixel of the image. Border centers
// read 0. The unit sustains one pixel per clock while the output buffer has
// room and no register write is settling; the result is registered in the
// output buffer on its input transfer. The rate is set by the line store RAM,
// whose registered read is prefetched for the next column during the current
// transfer (a one-column image is served by a write-to-read bypass). After
// reset and after every register write the input is held off while the
// remapped mask and the prefetched column settle. The line store has no reset
// and needs no clearing pass: results read 0 until their window is written.
// ----------------------------------------------------------------------------
`include "binary_morphology_window_unit_defines.svh"

module binary_morphology_window_unit import bmw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // pixel input
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_pixel_in,
   // result output
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_pixel_out,
   output logic              rsp_out_valid,
   output logic              rsp_frame_done,
   // register writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   mode_type              mode_ff;
   logic [SE_BITS-1:0]    se_mask_ff;
   logic [RAD_W-1:0]      radius_x_ff;
   logic [RAD_W-1:0]      radius_y_ff;
   logic [IW_W-1:0]       image_width_ff;
   logic [ROW_W-1:0]      image_height_ff;
   logic                  csr_transfer;
   logic                  settle_ff;

   assign csr_ready    = 1'b1;
   assign csr_transfer = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_ERODE;
         se_mask_ff      <= '1;
         radius_x_ff     <= RAD_W'(1);
         radius_y_ff     <= RAD_W'(1);
         image_width_ff  <= IW_W'(640);
         image_height_ff <= ROW_W'(480);
         settle_ff       <= 1'b1;
      end else begin
         settle_ff <= csr_transfer;
         if (csr_transfer) begin
            case (csr_index_type'(csr_index))
               CSR_MODE:         mode_ff         <= mode_type'(csr_wdata[0]);
               CSR_SE_MASK:      se_mask_ff      <= csr_wdata[SE_BITS-1:0];
               CSR_RADIUS_X:     radius_x_ff     <= csr_wdata[RAD_W-1:0];
               CSR_RADIUS_Y:     radius_y_ff     <= csr_wdata[RAD_W-1:0];
               CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[IW_W-1:0];
               CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[ROW_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Effective geometry: clamp radii, force zero sizes to one, cap the width.
   logic [RAD_W-1:0]    rx;
   logic [RAD_W-1:0]    ry;
   logic [CMP_W-1:0]    w_eff;
   logic [ROW_W-1:0]    h_eff;
   logic [WIN_BITS-1:0] win_mask_ff;

   assign rx = clamp_radius(radius_x_ff);
   assign ry = clamp_radius(radius_y_ff);

   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(image_width_ff) > CMP_W'(MAX_LINE)) begin
         w_eff = CMP_W'(MAX_LINE);
      end else begin
         w_eff = CMP_W'(image_width_ff);
      end
      h_eff = (image_height_ff == '0) ? ROW_W'(1) : image_height_ff;
   end

   // Mask is registered from the configuration registers, so it lags them; settle_ff covers the gap.
   always_ff @(posedge clock) begin
      win_mask_ff <= window_mask(se_mask_ff, rx, ry);
   end

   // ------------------------------------------------------------------
   // Raster position
   // ------------------------------------------------------------------
   logic                 req_transfer;
   logic                 buf_full;
   logic [LINE_AW-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 col_wrap;
   logic [LINE_AW-1:0]   cur_col;
   logic [ROW_W:0]       row_bump;
   logic [ROW_W-1:0]     cur_row;
   logic [COL_W-1:0]     col_next;
   logic [ROW_W:0]       row_next;
   logic                 row_end;
   logic                 frame_end_row;

   assign req_ready    = !settle_ff && !buf_full;
   assign req_transfer = req_valid && req_ready;

   always_comb begin
      // a register change may leave the counters past the end: wrap first
      col_wrap      = CMP_W'(col_ff) >= w_eff;
      cur_col       = col_wrap ? '0 : col_ff;
      row_bump      = col_wrap ? ({1'b0, row_ff} + (ROW_W+1)'(1)) : {1'b0, row_ff};
      cur_row       = (row_bump >= {1'b0, h_eff}) ? '0 : row_bump[ROW_W-1:0];
      col_next      = {1'b0, cur_col} + COL_W'(1);
      row_next      = {1'b0, cur_row} + (ROW_W+1)'(1);
      row_end       = CMP_W'(col_next) >= w_eff;
      frame_end_row = row_next >= {1'b0, h_eff};
      col_in        = col_ff;
      row_in        = row_ff;
      if (req_transfer) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end_row ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[LINE_AW-1:0];
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // Line store: prefetch the column of the next pixel every cycle
   // ------------------------------------------------------------------
   logic [LINE_AW-1:0]    rd_addr;
   logic [STORE_BITS-1:0] rd_data;
   logic [STORE_BITS-1:0] old_col;
   logic [WIN_SIDE-1:0]   new_col;
   logic                  fwd_valid_ff, fwd_valid_in;
   logic [STORE_BITS-1:0] fwd_data_ff;

   assign rd_addr      = (CMP_W'(col_in) >= w_eff) ? '0 : col_in;
   assign old_col      = fwd_valid_ff ? fwd_data_ff : rd_data;
   assign new_col      = {old_col, req_pixel_in};
   // same column read right after its write: bypass the stale read
   assign fwd_valid_in = req_transfer && (rd_addr == cur_col);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
      fwd_data_ff <= new_col[STORE_BITS-1:0];
   end

   bmw_ram #(
      .WIDTH (STORE_BITS),
      .DEPTH (MAX_LINE)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (req_transfer),
      .wr_addr (cur_col),
      .wr_data (new_col[STORE_BITS-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------------
   // Window: chain of column cells, newest column enters cell 0
   // ------------------------------------------------------------------
   logic [WIN_SIDE-1:0] cell_col [WIN_SIDE];
   cell_flags_type      cell_flags [WIN_SIDE];
   logic [WIN_SIDE-1:0] cell_any;
   logic [WIN_SIDE-1:0] cell_all;

   for (genvar a = 0; a < WIN_SIDE; a++) begin : g_cell
      logic [WIN_SIDE-1:0] prev_col;
      if (a == 0) begin : g_head
         assign prev_col = new_col;
      end else begin : g_link
         assign prev_col = cell_col[a-1];
      end
      bmw_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (req_transfer),
         .prev_col (prev_col),
         .mask     (win_mask_ff[a*WIN_SIDE +: WIN_SIDE]),
         .col_out  (cell_col[a]),
         .flags    (cell_flags[a])
      );
      assign cell_any[a] = cell_flags[a].any_set;
      assign cell_all[a] = cell_flags[a].all_set;
   end

   // ------------------------------------------------------------------
   // Result
   // ------------------------------------------------------------------
   logic    center_valid;
   logic    interior;
   rsp_type rsp_next;
   rsp_type rsp_data;

   assign center_valid = (cur_col >= LINE_AW'(rx)) && (cur_row >= ROW_W'(ry));
   assign interior     = center_valid && (cur_col >= LINE_AW'({rx, 1'b0}))
                         && (cur_row >= ROW_W'({ry, 1'b0}));

   always_comb begin
      rsp_next.out_valid  = center_valid;
      rsp_next.frame_done = row_end && frame_end_row;
      rsp_next.pixel_out  = 1'b0;
      if (interior) begin
         rsp_next.pixel_out = (mode_ff == MODE_DILATE) ? (|cell_any) : (&cell_all);
      end
   end

   bmw_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_load   (req_transfer),
      .in_data   (rsp_next),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .full      (buf_full)
   );

   assign rsp_pixel_out  = rsp_data.pixel_out;
   assign rsp_out_valid  = rsp_data.out_valid;
   assign rsp_frame_done = rsp_data.frame_done;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `BMW_ASSERT_NXT(a_rsp_follows_req, clock, reset, req_transfer, rsp_valid, "result missing after pixel transfer")
   `BMW_ASSERT_NXT(a_hold_after_csr, clock, reset, csr_transfer, !req_ready, "pixel accepted before configuration settled")
   `BMW_ASSERT_IMP(a_pixel_needs_valid, clock, reset, rsp_valid && rsp_pixel_out, rsp_out_valid, "pixel_out set on a result that is not valid")
   `BMW_ASSERT_NXT(a_col_in_range, clock, reset, req_transfer && !csr_transfer, CMP_W'(col_ff) < w_eff, "column counter past the line end")

endmodule
